FILE: sv/frsq_pkg.sv
// shared constants, types and helper functions for the reciprocal square root pipeline
package frsq_pkg;

	localparam logic [31:0] MAGIC_BITS  = 32'h5f3759df;
	localparam logic [31:0] HALF_BITS   = 32'h3f000000;
	localparam logic [31:0] ONE_P5_BITS = 32'h3fc00000;
	localparam logic [31:0] CANON_NAN   = 32'h7fc00000;
	localparam logic [7:0]  EXP_MAX     = 8'hff;

	typedef struct packed {
		logic en;
		logic valid;
	} pipe_ctrl_t;

	// position count of leading zeros, 48-bit product
	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd47;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) begin
				n = 6'(47 - i);
			end
		end
		return n;
	endfunction

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		n = 5'd26;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) begin
				n = 5'(26 - i);
			end
		end
		return n;
	endfunction

endpackage

FILE: sv/frsq_stream_if.sv
// valid/ready channels for operand and result transfers
interface frsq_operand_if;
	logic        valid;
	logic        ready;
	logic [31:0] operand_bits;
	modport source (output valid, output operand_bits, input ready);
	modport sink (input valid, input operand_bits, output ready);
endinterface

interface frsq_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_bits;
	modport source (output valid, output result_bits, input ready);
	modport sink (input valid, input result_bits, output ready);
endinterface

FILE: sv/frsq_fmul.sv
// two-stage single-precision multiplier, round to nearest even
module frsq_fmul (
	input  logic               clk,
	input  logic               arst_n,
	input  frsq_pkg::pipe_ctrl_t ctl,
	input  logic [31:0]        a,
	input  logic [31:0]        b,
	input  logic [31:0]        side,
	output logic               valid_out,
	output logic [31:0]        prod,
	output logic [31:0]        side_out
);
	import frsq_pkg::*;

	logic [7:0]  ea, eb;
	logic [22:0] fa, fb;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [23:0] ma, mb;
	logic [7:0]  eaf, ebf;

	logic               v_s1, sign_s1, nan_s1, inf_s1, zero_s1;
	logic [47:0]        prod_s1;
	logic signed [10:0] ebase_s1;
	logic [31:0]        side_s1;

	logic               v_s2;
	logic [31:0]        prod_s2, side_s2;

	logic [5:0]         lz;
	logic [47:0]        pn;
	logic signed [10:0] e, ef;
	logic [5:0]         sh;
	logic [95:0]        ext;
	logic [23:0]        m;
	logic               grd, st, inc;
	logic [24:0]        mr;
	logic [31:0]        packed_res;

	always_comb begin
		ea = a[30:23];
		eb = b[30:23];
		fa = a[22:0];
		fb = b[22:0];
		a_nan = (ea == EXP_MAX) && (fa != '0);
		b_nan = (eb == EXP_MAX) && (fb != '0);
		a_inf = (ea == EXP_MAX) && (fa == '0);
		b_inf = (eb == EXP_MAX) && (fb == '0);
		a_zero = (ea == '0) && (fa == '0);
		b_zero = (eb == '0) && (fb == '0);
		ma = {ea != '0, fa};
		mb = {eb != '0, fb};
		eaf = (ea == '0) ? 8'd1 : ea;
		ebf = (eb == '0) ? 8'd1 : eb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ctl.en) begin
			v_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			sign_s1  <= a[31] ^ b[31];
			nan_s1   <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
			inf_s1   <= a_inf || b_inf;
			zero_s1  <= a_zero || b_zero;
			prod_s1  <= 48'(ma) * 48'(mb);
			ebase_s1 <= $signed({3'b000, eaf}) + $signed({3'b000, ebf}) - 11'sd126;
			side_s1  <= side;
		end
	end

	// normalize, denormalize on underflow, round
	always_comb begin
		lz  = lzc48(prod_s1);
		pn  = prod_s1 << lz;
		e   = ebase_s1 - $signed({5'b00000, lz});
		if (e < 11'sd1) begin
			sh = ((11'sd1 - e) > 11'sd50) ? 6'd50 : 6'(11'sd1 - e);
		end else begin
			sh = 6'd0;
		end
		ext = {pn, 48'b0} >> sh;
		m   = ext[95:72];
		grd = ext[71];
		st  = |ext[70:0];
		inc = grd && (st || m[0]);
		mr  = {1'b0, m} + {24'b0, inc};
		if (e >= 11'sd1) begin
			ef = mr[24] ? (e + 11'sd1) : e;
		end else begin
			ef = mr[23] ? 11'sd1 : 11'sd0;
		end
		if (ef >= 11'sd255) begin
			packed_res = {sign_s1, EXP_MAX, 23'b0};
		end else begin
			packed_res = {sign_s1, ef[7:0], mr[22:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ctl.en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			side_s2 <= side_s1;
			if (nan_s1) begin
				prod_s2 <= CANON_NAN;
			end else if (inf_s1) begin
				prod_s2 <= {sign_s1, EXP_MAX, 23'b0};
			end else if (zero_s1) begin
				prod_s2 <= {sign_s1, 31'b0};
			end else begin
				prod_s2 <= packed_res;
			end
		end
	end

	assign valid_out = v_s2;
	assign prod      = prod_s2;
	assign side_out  = side_s2;

endmodule

FILE: sv/frsq_fadd.sv
// two-stage single-precision adder, round to nearest even
module frsq_fadd (
	input  logic               clk,
	input  logic               arst_n,
	input  frsq_pkg::pipe_ctrl_t ctl,
	input  logic [31:0]        a,
	input  logic [31:0]        b,
	input  logic [31:0]        side,
	output logic               valid_out,
	output logic [31:0]        sum,
	output logic [31:0]        side_out
);
	import frsq_pkg::*;

	logic [7:0]  ea, eb, ebig, esml, ex, ey, d;
	logic [22:0] fa, fb;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, swap;
	logic [31:0] big, sml;
	logic [4:0]  dcap;
	logic [26:0] mx27, ym;
	logic [53:0] al;
	logic [27:0] raw;

	logic        v_s1, sign_s1, nan_s1, inf_s1, inf_sign_s1, bzero_s1, zsign_s1;
	logic [27:0] sum_s1;
	logic [7:0]  exp_s1;
	logic [31:0] side_s1;

	logic        v_s2;
	logic [31:0] sum_s2, side_s2;

	logic [4:0]  lz, sh, maxsh;
	logic [26:0] s27;
	logic [8:0]  e2, ef;
	logic [23:0] m;
	logic        grd, st, inc;
	logic [24:0] mr;
	logic [31:0] packed_res;

	always_comb begin
		ea = a[30:23];
		eb = b[30:23];
		fa = a[22:0];
		fb = b[22:0];
		a_nan = (ea == EXP_MAX) && (fa != '0);
		b_nan = (eb == EXP_MAX) && (fb != '0);
		a_inf = (ea == EXP_MAX) && (fa == '0);
		b_inf = (eb == EXP_MAX) && (fb == '0);
		a_zero = (ea == '0) && (fa == '0);
		b_zero = (eb == '0) && (fb == '0);
		swap = a[30:0] < b[30:0];
		big  = swap ? b : a;
		sml  = swap ? a : b;
		ebig = big[30:23];
		esml = sml[30:23];
		ex   = (ebig == '0) ? 8'd1 : ebig;
		ey   = (esml == '0) ? 8'd1 : esml;
		d    = ex - ey;
		dcap = (d > 8'd28) ? 5'd28 : d[4:0];
		mx27 = {ebig != '0, big[22:0], 3'b000};
		// align the smaller operand, folding shifted-out bits into sticky
		al   = {esml != '0, sml[22:0], 3'b000, 27'b0} >> dcap;
		ym   = al[53:27] | {26'b0, |al[26:0]};
		if (big[31] != sml[31]) begin
			raw = {1'b0, mx27} - {1'b0, ym};
		end else begin
			raw = {1'b0, mx27} + {1'b0, ym};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ctl.en) begin
			v_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			nan_s1      <= a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]));
			inf_s1      <= a_inf || b_inf;
			inf_sign_s1 <= a_inf ? a[31] : b[31];
			bzero_s1    <= a_zero && b_zero;
			zsign_s1    <= a[31] && b[31];
			sign_s1     <= big[31];
			sum_s1      <= raw;
			exp_s1      <= ex;
			side_s1     <= side;
		end
	end

	always_comb begin
		lz    = lzc27(sum_s1[26:0]);
		maxsh = (exp_s1 > 8'd27) ? 5'd27 : 5'(exp_s1 - 8'd1);
		sh    = (lz < maxsh) ? lz : maxsh;
		if (sum_s1[27]) begin
			s27 = sum_s1[27:1] | {26'b0, sum_s1[0]};
			e2  = {1'b0, exp_s1} + 9'd1;
		end else begin
			s27 = sum_s1[26:0] << sh;
			e2  = {1'b0, exp_s1} - {4'b0, sh};
		end
		m   = s27[26:3];
		grd = s27[2];
		st  = |s27[1:0];
		inc = grd && (st || m[0]);
		mr  = {1'b0, m} + {24'b0, inc};
		if (mr[24]) begin
			ef = e2 + 9'd1;
		end else if (mr[23]) begin
			ef = e2;
		end else begin
			ef = 9'd0;
		end
		if (ef >= 9'd255) begin
			packed_res = {sign_s1, EXP_MAX, 23'b0};
		end else begin
			packed_res = {sign_s1, ef[7:0], mr[22:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ctl.en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			side_s2 <= side_s1;
			if (nan_s1) begin
				sum_s2 <= CANON_NAN;
			end else if (inf_s1) begin
				sum_s2 <= {inf_sign_s1, EXP_MAX, 23'b0};
			end else if (bzero_s1) begin
				sum_s2 <= {zsign_s1, 31'b0};
			end else if (sum_s1 == '0) begin
				// exact cancellation gives positive zero
				sum_s2 <= 32'b0;
			end else begin
				sum_s2 <= packed_res;
			end
		end
	end

	assign valid_out = v_s2;
	assign sum       = sum_s2;
	assign side_out  = side_s2;

endmodule

FILE: sv/fast_inverse_sqrt_float32.sv
// Approximate reciprocal square root of single-precision bit patterns.
// operand channel: one 32-bit pattern x per transfer (valid/ready).
// result channel: one 32-bit pattern y per transfer, in input order.
// The guess is the magic constant minus x shifted right arithmetically,
// refined by one Newton step: y = g * (1.5 - ((x*0.5)*g)*g).
// Every operation rounds to nearest even; subnormals, infinities kept,
// any NaN result comes out as 0x7fc00000.
// Pipeline: 10 register stages, set by five chained two-stage float units
// (four multiplies, one subtract).
// Throughput: one item per cycle while the result side takes them.
// When the result is not taken the whole pipeline holds in place and
// operand ready drops; nothing is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
module fast_inverse_sqrt_float32 (
	input  logic               clk,
	input  logic               arst_n,
	frsq_operand_if.sink       operand,
	frsq_result_if.source      result
);
	import frsq_pkg::*;

	logic        en;
	pipe_ctrl_t  c0, c1, c2, c3, c4;
	logic        v1, v2, v3, v4, v5;
	logic [31:0] guess;
	logic [31:0] half, g1, t1, g2, t2, g3, dif, g4, y, unused_side;

	assign en = !result.valid || result.ready;
	assign operand.ready = en;

	assign guess = MAGIC_BITS - {operand.operand_bits[31], operand.operand_bits[31:1]};

	assign c0 = '{en: en, valid: operand.valid};
	assign c1 = '{en: en, valid: v1};
	assign c2 = '{en: en, valid: v2};
	assign c3 = '{en: en, valid: v3};
	assign c4 = '{en: en, valid: v4};

	frsq_fmul u_half (
		.clk, .arst_n, .ctl(c0), .a(operand.operand_bits), .b(HALF_BITS),
		.side(guess), .valid_out(v1), .prod(half), .side_out(g1)
	);

	frsq_fmul u_t1 (
		.clk, .arst_n, .ctl(c1), .a(half), .b(g1),
		.side(g1), .valid_out(v2), .prod(t1), .side_out(g2)
	);

	frsq_fmul u_t2 (
		.clk, .arst_n, .ctl(c2), .a(t1), .b(g2),
		.side(g2), .valid_out(v3), .prod(t2), .side_out(g3)
	);

	frsq_fadd u_dif (
		.clk, .arst_n, .ctl(c3), .a(ONE_P5_BITS), .b({~t2[31], t2[30:0]}),
		.side(g3), .valid_out(v4), .sum(dif), .side_out(g4)
	);

	frsq_fmul u_y (
		.clk, .arst_n, .ctl(c4), .a(g4), .b(dif),
		.side(32'b0), .valid_out(v5), .prod(y), .side_out(unused_side)
	);

	assign result.valid       = v5;
	assign result.result_bits = y;

	// all NaN results leave in canonical form
	a_canon_nan: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.result_bits[30:23] == EXP_MAX)
			&& (result.result_bits[22:0] != '0))
		|-> (result.result_bits == CANON_NAN))
		else $error("non-canonical nan on result");

	// input side only stalls behind a held result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!operand.ready |-> (result.valid && !result.ready))
		else $error("operand stalled without result backpressure");

	// a held result stays valid into the next cycle
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> (result.valid && (unused_side == '0)))
		else $error("held result dropped");

endmodule
